### src/rtte_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the RTT estimator and retransmission timeout unit.
package rtte_pkg;

  localparam int unsigned FRAC_BITS_DEF = 4;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIME_W-1:0] NO_ECHO = 16'hFFFF;

  localparam logic [TIME_W-1:0] SRTT_RESET_MS   = 16'd1000;
  localparam logic [TIME_W-1:0] RTTVAR_RESET_MS = 16'd500;
  localparam logic [TIME_W-1:0] MIN_TO_RESET_MS = 16'd50;
  localparam logic [TIME_W-1:0] MAX_TO_RESET_MS = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_TIMEOUT = 2'd0,
    CFG_MAX_TIMEOUT = 2'd1
  } cfg_idx_e;

endpackage

### src/rtt_estimator_rto_unit.sv
`timescale 1ns / 1ps
// Top level: RTT estimator with retransmission timeout output.
// A result passes through the stage 1, stage 2 and result registers in order.
// Throughput: one beat per cycle unless stalled; estimate update is combinational
// on the SRTT/RTTVAR registers, and the timeout is computed in the next stage.
// Reset: estimates return to 1000 ms / 500 ms, bounds to 50 ms / 1000 ms,
// the first-sample flag clears and all pipeline stages empty.
module rtt_estimator_rto_unit import rtte_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TIME_W-1:0]     now_time_i,
  input  logic [TIME_W-1:0]     echo_time_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TIME_W-1:0]     rto_ms_o,
  output logic [TIME_W-1:0]     smoothed_rtt_ms_o,
  output logic                  sample_taken_o
);

  localparam int unsigned StW = TIME_W + FracBits;
  localparam logic [StW-1:0] SrttReset   = StW'(SRTT_RESET_MS) << FracBits;
  localparam logic [StW-1:0] RttvarReset = StW'(RTTVAR_RESET_MS) << FracBits;

  // configuration registers
  logic [TIME_W-1:0] min_to_q, min_to_d;
  logic [TIME_W-1:0] max_to_q, max_to_d;

  // estimator state
  logic [StW-1:0] srtt_q, srtt_d;
  logic [StW-1:0] rttvar_q, rttvar_d;
  logic           first_seen_q, first_seen_d;

  // stage 1: captured input beat
  logic              s1_valid_q, s1_valid_d;
  logic [TIME_W-1:0] s1_now_q, s1_echo_q;

  // stage 2: snapshot of the estimates after this beat
  logic           s2_valid_q, s2_valid_d;
  logic [StW-1:0] s2_srtt_q, s2_rttvar_q;
  logic           s2_taken_q;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [TIME_W-1:0] out_timeout_q, out_srtt_ms_q;
  logic              out_taken_q;

  // update results and timeout
  logic [StW-1:0]    upd_srtt, upd_rttvar;
  logic              upd_taken;
  logic [TIME_W-1:0] rto_ms;

  // flow control: each stage loads when empty or when its contents move on
  logic out_load, s2_load, s1_fire, in_fire;

  assign out_load   = !out_valid_q || out_ready_i;
  assign s2_load    = !s2_valid_q || out_load;
  assign s1_fire    = s1_valid_q && s2_load;
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_fire    = in_valid_i && in_ready_o;

  rtte_update #(
    .FracBits(FracBits)
  ) u_update (
    .srtt_i      (srtt_q),
    .rttvar_i    (rttvar_q),
    .first_seen_i(first_seen_q),
    .now_time_i  (s1_now_q),
    .echo_time_i (s1_echo_q),
    .srtt_o      (upd_srtt),
    .rttvar_o    (upd_rttvar),
    .taken_o     (upd_taken)
  );

  rtte_rto #(
    .FracBits(FracBits)
  ) u_rto (
    .srtt_i       (s2_srtt_q),
    .rttvar_i     (s2_rttvar_q),
    .min_timeout_i(min_to_q),
    .max_timeout_i(max_to_q),
    .timeout_o    (rto_ms)
  );

  // configuration decode; unknown indexes are dropped
  always_comb begin
    min_to_d = min_to_q;
    max_to_d = max_to_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_TIMEOUT: min_to_d = cfg_wdata_i[TIME_W-1:0];
        CFG_MAX_TIMEOUT: max_to_d = cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the estimates only when a beat leaves stage 1
  always_comb begin
    srtt_d       = srtt_q;
    rttvar_d     = rttvar_q;
    first_seen_d = first_seen_q;
    if (s1_fire) begin
      srtt_d   = upd_srtt;
      rttvar_d = upd_rttvar;
      if (upd_taken) begin
        first_seen_d = 1'b1;
      end
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s2_valid_d  = s2_valid_q;
    out_valid_d = out_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    if (s2_load) begin
      s2_valid_d = s1_valid_q;
    end
    if (out_load) begin
      out_valid_d = s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_to_q     <= MIN_TO_RESET_MS;
      max_to_q     <= MAX_TO_RESET_MS;
      srtt_q       <= SrttReset;
      rttvar_q     <= RttvarReset;
      first_seen_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      min_to_q     <= min_to_d;
      max_to_q     <= max_to_d;
      srtt_q       <= srtt_d;
      rttvar_q     <= rttvar_d;
      first_seen_q <= first_seen_d;
      s1_valid_q   <= s1_valid_d;
      s2_valid_q   <= s2_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers: hold while stalled, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_now_q  <= now_time_i;
      s1_echo_q <= echo_time_i;
    end
    if (s1_fire) begin
      s2_srtt_q   <= upd_srtt;
      s2_rttvar_q <= upd_rttvar;
      s2_taken_q  <= upd_taken;
    end
    if (out_load && s2_valid_q) begin
      out_timeout_q <= rto_ms;
      out_srtt_ms_q <= s2_srtt_q[StW-1:FracBits];
      out_taken_q   <= s2_taken_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign rto_ms_o          = out_timeout_q;
  assign smoothed_rtt_ms_o = out_srtt_ms_q;
  assign sample_taken_o    = out_taken_q;

`ifndef SYNTHESIS
  // a beat without an echo must leave the estimates alone
  a_no_echo_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_echo_q == NO_ECHO) |=> $stable(srtt_q) && $stable(rttvar_q))
    else $error("estimates changed on a beat without echo");

  // a taken sample marks the first sample as seen
  a_first_seen_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_echo_q != NO_ECHO) |=> first_seen_q)
    else $error("first-sample flag not set after a taken sample");

  // a result reporting a taken sample implies the flag is already set
  a_taken_implies_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_taken_q |-> first_seen_q)
    else $error("taken result without first-sample flag");

  // stage 1 is never overwritten while it still holds a beat
  a_s1_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_load |-> !in_ready_o)
    else $error("input accepted while stage 1 is blocked");
`endif

endmodule

### src/rtte_update.sv
`timescale 1ns / 1ps
// Next-state logic for the smoothed RTT and RTT variance estimates.
module rtte_update import rtte_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic [TIME_W+FracBits-1:0] srtt_i,
  input  logic [TIME_W+FracBits-1:0] rttvar_i,
  input  logic                       first_seen_i,
  input  logic [TIME_W-1:0]          now_time_i,
  input  logic [TIME_W-1:0]          echo_time_i,
  output logic [TIME_W+FracBits-1:0] srtt_o,
  output logic [TIME_W+FracBits-1:0] rttvar_o,
  output logic                       taken_o
);

  localparam int unsigned StW     = TIME_W + FracBits;
  localparam int unsigned VarSumW = StW + 2;
  localparam int unsigned SrtSumW = StW + 3;

  logic [TIME_W-1:0]  sample;
  logic [StW-1:0]     sample_fx;
  logic [StW-1:0]     dev;
  logic [VarSumW-1:0] var_sum;
  logic [SrtSumW-1:0] srtt_sum;

  assign taken_o   = (echo_time_i != NO_ECHO);
  assign sample    = now_time_i - echo_time_i;
  assign sample_fx = {sample, {FracBits{1'b0}}};

  // absolute deviation against the old estimate
  assign dev = (srtt_i > sample_fx) ? (srtt_i - sample_fx) : (sample_fx - srtt_i);

  // 3*var + dev and 7*srtt + sample, both exact before the truncating shift
  assign var_sum  = (VarSumW'(rttvar_i) << 1) + VarSumW'(rttvar_i) + VarSumW'(dev);
  assign srtt_sum = (SrtSumW'(srtt_i) << 3) - SrtSumW'(srtt_i) + SrtSumW'(sample_fx);

  always_comb begin
    srtt_o   = srtt_i;
    rttvar_o = rttvar_i;
    if (taken_o) begin
      if (!first_seen_i) begin
        srtt_o   = sample_fx;
        rttvar_o = sample_fx >> 1;
      end else begin
        srtt_o   = srtt_sum[SrtSumW-1:3];
        rttvar_o = var_sum[VarSumW-1:2];
      end
    end
  end

endmodule

### src/rtte_rto.sv
`timescale 1ns / 1ps
// Retransmission timeout: ceil(SRTT + 4*RTTVAR) clamped to the configured bounds.
module rtte_rto import rtte_pkg::*; #(
  parameter int unsigned FracBits = FRAC_BITS_DEF
) (
  input  logic [TIME_W+FracBits-1:0] srtt_i,
  input  logic [TIME_W+FracBits-1:0] rttvar_i,
  input  logic [TIME_W-1:0]          min_timeout_i,
  input  logic [TIME_W-1:0]          max_timeout_i,
  output logic [TIME_W-1:0]          timeout_o
);

  localparam int unsigned StW  = TIME_W + FracBits;
  localparam int unsigned SumW = StW + 3;
  localparam int unsigned MsW  = SumW - FracBits;
  localparam logic [SumW-1:0] RoundUp = SumW'((2 ** FracBits) - 1);

  logic [SumW-1:0] sum;
  logic [MsW-1:0]  ceil_ms;
  logic [MsW-1:0]  lo_clamped;

  assign sum     = SumW'(srtt_i) + (SumW'(rttvar_i) << 2) + RoundUp;
  assign ceil_ms = sum[SumW-1:FracBits];

  // minimum first, then maximum, so the maximum wins when the bounds cross
  assign lo_clamped = (ceil_ms < MsW'(min_timeout_i)) ? MsW'(min_timeout_i) : ceil_ms;
  assign timeout_o  = (lo_clamped > MsW'(max_timeout_i)) ? max_timeout_i
                                                          : lo_clamped[TIME_W-1:0];

endmodule
